// File: sv/sltab_pkg.sv
package sltab_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths fixed by the transaction format
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int ECNT_W   = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// Flags from the shared compare unit: a against b
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

	// Result handed from the sequencer to the output stage
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [ECNT_W-1:0]   entry_count;
	} res_t;

	// Report the count in the result width, wrapping for large tables
	function automatic logic [ECNT_W-1:0] to_entry_count(input cnt_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[ECNT_W-1:0];
	endfunction

endpackage

// File: sv/sltab_req_if.sv
interface sltab_req_if;
	logic                                valid;
	logic                                ready;
	logic [sltab_pkg::CMD_W-1:0]         command;
	logic signed [sltab_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

// File: sv/sltab_res_if.sv
interface sltab_res_if;
	logic                             valid;
	logic                             ready;
	logic [sltab_pkg::STATUS_W-1:0]   status;
	logic                             found;
	logic [sltab_pkg::ECNT_W-1:0]     entry_count;

	modport source (output valid, output status, output found, output entry_count, input ready);
	modport sink   (input valid, input status, input found, input entry_count, output ready);
endinterface

// File: sv/sorted_list_table_engine_top.sv
// Sorted table engine: holds up to TABLE_DEPTH signed 32-bit values in ascending order
// (duplicates kept) and runs one insert, delete or search per request transaction,
// answering with one result transaction of status, found flag and entry count. The
// table sits in a memory with one write port and a registered read, so every entry
// scanned or moved takes a read step and then a compare or write step. An insert
// moves each stored entry at or above the value up one place, a search passes the
// smaller entries, a delete runs its search and then shifts the entries behind the
// match down, and a full-table insert or an unused command goes straight to the
// result. The result is registered on the same edge on which the request side
// becomes ready again. The request side stays not ready while an operation runs; a
// finished result waits in an output register, so the next request is taken while
// it is still pending.
module sorted_list_table_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	sltab_req_if.sink          req,
	sltab_res_if.source        res
);

	logic            core_ready;
	logic            core_res_valid;
	logic            core_res_ready;
	sltab_pkg::res_t core_res;
	logic            res_valid_q;
	sltab_pkg::res_t res_q;

	assign req.ready = core_ready;

	sltab_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid & core_ready),
		.cmd       (req.command),
		.value     (req.value),
		.ready     (core_ready),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res)
	);

	// Output register: take a new result when empty or being drained
	assign core_res_ready = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_res_ready) begin
			res_valid_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_ready && core_res_valid) begin
			res_q <= core_res;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = res_q.status;
	assign res.found       = res_q.found;
	assign res.entry_count = res_q.entry_count;

endmodule

// File: sv/sltab_cmp.sv
module sltab_cmp (
	input  sltab_pkg::value_t a,
	input  sltab_pkg::value_t b,
	output sltab_pkg::cmp_t   flags
);

	// Two's complement signed compare shared by every scan step
	always_comb begin
		flags.lt = (a < b);
		flags.eq = (a == b);
	end

endmodule

// File: sv/sltab_core.sv
module sltab_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sltab_pkg::CMD_W-1:0]    cmd,
	input  sltab_pkg::value_t              value,
	output logic                           ready,
	output logic                           res_valid,
	input  logic                           res_ready,
	output sltab_pkg::res_t                res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_SCH_RD,
		S_SCH_CHK,
		S_DEL_RD,
		S_DEL_WR,
		S_FINISH
	} state_t;

	state_t                           state_q;
	logic [sltab_pkg::CMD_W-1:0]      cmd_q;
	sltab_pkg::value_t                key_q;
	sltab_pkg::cnt_t                  count_q;
	sltab_pkg::cnt_t                  i_q;
	logic [sltab_pkg::STATUS_W-1:0]   status_q;
	logic                             found_q;

	// Table storage, single write port and registered read
	sltab_pkg::value_t                mem [sltab_pkg::TABLE_DEPTH];
	sltab_pkg::value_t                rdata_q;
	sltab_pkg::idx_t                  raddr;
	logic                             mem_re;
	sltab_pkg::idx_t                  waddr;
	sltab_pkg::value_t                wdata;
	logic                             mem_we;

	sltab_pkg::cnt_t                  i_dec;
	sltab_pkg::cnt_t                  i_inc;
	sltab_pkg::cmp_t                  cmp;

	assign i_dec = i_q - sltab_pkg::cnt_t'(1);
	assign i_inc = i_q + sltab_pkg::cnt_t'(1);

	sltab_cmp u_cmp (
		.a     (rdata_q),
		.b     (key_q),
		.flags (cmp)
	);

	// Select memory address and data for the current step
	always_comb begin
		raddr  = i_q[sltab_pkg::IDX_W-1:0];
		mem_re = 1'b0;
		waddr  = i_q[sltab_pkg::IDX_W-1:0];
		wdata  = rdata_q;
		mem_we = 1'b0;
		case (state_q)
			S_INS_RD: begin
				raddr  = i_dec[sltab_pkg::IDX_W-1:0];
				mem_re = 1'b1;
				if (i_q == '0) begin
					wdata  = key_q;
					mem_we = 1'b1;
				end
			end
			S_INS_CHK: begin
				wdata  = cmp.lt ? key_q : rdata_q;
				mem_we = 1'b1;
			end
			S_SCH_RD: begin
				mem_re = 1'b1;
			end
			S_DEL_RD: begin
				raddr  = i_inc[sltab_pkg::IDX_W-1:0];
				mem_re = 1'b1;
			end
			S_DEL_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Sequencer: insert walks down from the top, delete and search walk up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			i_q      <= '0;
			cmd_q    <= sltab_pkg::CMD_INSERT;
			key_q    <= '0;
			status_q <= sltab_pkg::ST_DONE;
			found_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd;
						key_q    <= value;
						found_q  <= 1'b0;
						status_q <= sltab_pkg::ST_DONE;
						case (cmd)
							sltab_pkg::CMD_INSERT: begin
								if (count_q == sltab_pkg::cnt_t'(sltab_pkg::TABLE_DEPTH)) begin
									status_q <= sltab_pkg::ST_FULL;
									state_q  <= S_FINISH;
								end else begin
									i_q     <= count_q;
									state_q <= S_INS_RD;
								end
							end
							sltab_pkg::CMD_DELETE, sltab_pkg::CMD_SEARCH: begin
								i_q     <= '0;
								state_q <= S_SCH_RD;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						count_q <= count_q + sltab_pkg::cnt_t'(1);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					if (!cmp.lt) begin
						// Entry not below key: moved up, keep walking down
						i_q     <= i_dec;
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + sltab_pkg::cnt_t'(1);
						state_q <= S_FINISH;
					end
				end
				S_SCH_RD: begin
					if (i_q == count_q) begin
						status_q <= sltab_pkg::ST_ABSENT;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_SCH_CHK;
					end
				end
				S_SCH_CHK: begin
					if (cmp.lt) begin
						i_q     <= i_inc;
						state_q <= S_SCH_RD;
					end else if (cmp.eq) begin
						found_q <= 1'b1;
						state_q <= (cmd_q == sltab_pkg::CMD_DELETE) ? S_DEL_RD : S_FINISH;
					end else begin
						status_q <= sltab_pkg::ST_ABSENT;
						state_q  <= S_FINISH;
					end
				end
				S_DEL_RD: begin
					if (i_inc == count_q) begin
						count_q <= count_q - sltab_pkg::cnt_t'(1);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					i_q     <= i_inc;
					state_q <= S_DEL_RD;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);

	always_comb begin
		res.status      = status_q;
		res.found       = found_q;
		res.entry_count = sltab_pkg::to_entry_count(count_q);
	end

endmodule

// File: verif/sorted_table_checker.sv
module sorted_table_checker
	import sltab_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sltab_req_if  req,
	sltab_res_if  res,
	output int    errors,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the table contents and its fill level
	value_t stored_vals [TABLE_DEPTH];
	int     held = 0;
	res_t   awaited_results [$];

	// Apply one operation to the shadow table and return the answer it should give
	function automatic res_t apply_table_op(input logic [CMD_W-1:0] cmd, input value_t v);
		res_t r;
		int   pos;
		int   i;
		r.status = ST_DONE;
		r.found  = 1'b0;
		pos = 0;
		case (cmd)
			CMD_INSERT: begin
				if (held >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					while (pos < held && stored_vals[pos] < v) pos++;
					for (i = held; i > pos; i--) stored_vals[i] = stored_vals[i-1];
					stored_vals[pos] = v;
					held++;
				end
			end
			CMD_DELETE, CMD_SEARCH: begin
				while (pos < held && stored_vals[pos] < v) pos++;
				if (pos < held && stored_vals[pos] == v) begin
					r.found = 1'b1;
					if (cmd == CMD_DELETE) begin
						for (i = pos; i + 1 < held; i++) stored_vals[i] = stored_vals[i+1];
						held--;
					end
				end else begin
					r.status = ST_ABSENT;
				end
			end
			default: ;
		endcase
		r.entry_count = ECNT_W'(held);
		return r;
	endfunction

	// Clear the counts in reset; otherwise retire results against the oldest
	// expectation, then log new requests
	always @(posedge clk) begin
		res_t exp_r;
		logic bad;
		if (!arst_n) begin
			errors  = 0;
			pending = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited: status %0d found %0d count %0d",
						$time, res.status, res.found, res.entry_count);
					errors++;
				end else begin
					exp_r = awaited_results.pop_front();
					pending--;
					bad = 1'b0;
					if (res.status !== exp_r.status) begin
						$display("%0t: status expected %0d got %0d", $time, exp_r.status, res.status);
						bad = 1'b1;
					end
					if (res.found !== exp_r.found) begin
						$display("%0t: found expected %0d got %0d", $time, exp_r.found, res.found);
						bad = 1'b1;
					end
					if (res.entry_count !== exp_r.entry_count) begin
						$display("%0t: entry_count expected %0d got %0d",
							$time, exp_r.entry_count, res.entry_count);
						bad = 1'b1;
					end
					if (bad) errors++;
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.push_back(apply_table_op(req.command, req.value));
				pending++;
			end
		end
	end

endmodule

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sltab_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam value_t VAL_MIN   = value_t'(32'h8000_0000);
	localparam value_t VAL_MAX   = value_t'(32'h7FFF_FFFF);
	localparam int RANDOM_ITEMS  = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1000000;

	logic clk;
	logic arst_n;
	int   err_cnt;
	int   pending_cnt;
	int   cycles = 0;
	bit   hold_res = 1'b0;

	sltab_req_if req_ch();
	sltab_res_if res_ch();

	sorted_list_table_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	sorted_table_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.errors  (err_cnt),
		.pending (pending_cnt)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it
	task automatic offer(input logic [CMD_W-1:0] cmd, input value_t v);
		req_ch.valid   = 1'b1;
		req_ch.command = cmd;
		req_ch.value   = v;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid for a number of cycles
	task automatic idle(input int n);
		if (n > 0) begin
			req_ch.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Mostly a small pool of keys so hits and duplicates are common
	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0, 1: pick_value = value_t'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: pick_value = VAL_MIN;
					1: pick_value = VAL_MAX;
					2: pick_value = -1;
					default: pick_value = 0;
				endcase
			end
			default: pick_value = value_t'(int'($urandom_range(0, 15)) - 8);
		endcase
	endfunction

	// Bias toward inserts while filling, toward deletes while draining
	function automatic logic [CMD_W-1:0] pick_cmd(input bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return CMD_UNUSED;
		if (filling) begin
			if (r < 65) return CMD_INSERT;
			if (r < 85) return CMD_DELETE;
			return CMD_SEARCH;
		end
		if (r < 25) return CMD_INSERT;
		if (r < 75) return CMD_DELETE;
		return CMD_SEARCH;
	endfunction

	// Request side: directed items, then bursts of random items
	initial begin
		int  n;
		int  burst;
		bit  filling;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_INSERT;
		req_ch.value   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extremes, duplicates, hits and misses, unused command
		offer(CMD_SEARCH, 0);
		offer(CMD_DELETE, VAL_MIN);
		offer(CMD_INSERT, VAL_MAX);
		offer(CMD_INSERT, VAL_MIN);
		offer(CMD_INSERT, 0);
		offer(CMD_INSERT, 0);
		offer(CMD_INSERT, -1);
		offer(CMD_SEARCH, 0);
		offer(CMD_SEARCH, VAL_MIN);
		offer(CMD_SEARCH, 5);
		offer(CMD_UNUSED, VAL_MAX);
		offer(CMD_DELETE, 0);
		offer(CMD_SEARCH, 0);
		offer(CMD_DELETE, 7);
		offer(CMD_DELETE, VAL_MIN);
		offer(CMD_DELETE, VAL_MAX);
		offer(CMD_SEARCH, VAL_MAX);
		offer(CMD_INSERT, value_t'(32'h5555_5555));
		offer(CMD_INSERT, value_t'(32'hAAAA_AAAA));
		offer(CMD_DELETE, value_t'(32'hAAAA_AAAA));
		offer(CMD_SEARCH, value_t'(32'h5555_5555));

		n = 0;
		filling = 1'b1;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				offer(pick_cmd(filling), pick_value());
				n++;
				if (n % 150 == 0) filling = !filling;
				// Stall the result side while requests keep coming
				if (n == 600) begin
					hold_res = 1'b1;
					repeat (30) begin
						offer(pick_cmd(filling), pick_value());
						n++;
					end
				end
				// Let everything drain before going on
				if (n == 1200) begin
					idle(1);
					while (pending_cnt != 0) @(negedge clk);
					idle(DRAIN_CYCLES);
				end
			end
			if ($urandom_range(0, 3) == 0) idle(0);
			else idle($urandom_range(1, 10));
		end

		req_ch.valid = 1'b0;
		while (pending_cnt != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Result side: stall patterns that change every so often
	initial begin
		int mode;
		int span;
		int k;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_res) begin
					res_ch.ready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_res = 1'b0;
				end
				case (mode)
					0: res_ch.ready = 1'b1;
					1: res_ch.ready = $urandom_range(0, 1);
					2: res_ch.ready = ($urandom_range(0, 3) == 0);
					default: res_ch.ready = (k % 3 == 0);
				endcase
			end
		end
	end

endmodule
